// ===== sv/gar_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared types and constants of the glyph attribute renderer.
package gar_pkg;

  // Pixel and row indexes are carried at the widest glyph size.
  localparam int IDX_W = 4;
  // A glyph row never spans more than this many font bytes.
  localparam int ROW_FETCH_BYTES = 3;
  localparam int FETCH_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_GLYPH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SCALE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDERLINE_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDERLINE_LEVEL  = 2'd3;

  localparam logic KIND_FONT_WRITE = 1'b0;
  localparam logic KIND_RENDER     = 1'b1;

  localparam logic [7:0] BOLD_THRESHOLD = 8'd64;
  localparam logic [7:0] PIX_FULL       = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WAIT,
    ST_EMIT
  } gar_state_t;

  typedef struct packed {
    logic               font_write;
    logic               start;
    logic               fetch;
    logic [FETCH_W-1:0] fetch_k;
    logic               emit;
    logic               last;
    logic [IDX_W-1:0]   x;
    logic [IDX_W-1:0]   y;
  } gar_cmd_t;

  typedef struct packed {
    logic advance;
    logic busy;
  } gar_status_t;

endpackage

// ===== sv/gar_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module gar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/gar_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences row fetches and pixel emission.
module gar_ctrl import gar_pkg::*; #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  input  gar_status_t status,
  output gar_cmd_t    cmd
);

  localparam int XW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int YW = $clog2(GLYPH_HEIGHT);
  localparam logic [XW-1:0] X_LAST = XW'(GLYPH_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GLYPH_HEIGHT - 1);
  localparam logic [FETCH_W-1:0] K_LAST = FETCH_W'(ROW_FETCH_BYTES - 1);

  gar_state_t state_r, state_nxt;
  logic [XW-1:0]      x_r, x_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [FETCH_W-1:0] k_r, k_nxt;
  logic               accept;

  assign in_ready = (state_r == ST_IDLE) && !status.busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_RENDER) begin
          state_nxt = ST_FETCH;
          y_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_FETCH: begin
        k_nxt = k_r + 1'b1;
        if (k_r == K_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_EMIT;
        x_nxt     = '0;
      end
      ST_EMIT: begin
        if (status.advance) begin
          x_nxt = x_r + 1'b1;
          if (x_r == X_LAST) begin
            if (y_r == Y_LAST) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_FETCH;
              y_nxt     = y_r + 1'b1;
              k_nxt     = '0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.font_write = accept && in_kind == KIND_FONT_WRITE;
    cmd.start      = accept && in_kind == KIND_RENDER;
    cmd.x          = IDX_W'(x_r);
    cmd.y          = IDX_W'(y_r);
    cmd.fetch_k    = k_r;
    case (state_r)
      ST_FETCH: cmd.fetch = 1'b1;
      ST_EMIT: begin
        cmd.emit = status.advance;
        cmd.last = status.advance && x_r == X_LAST && y_r == Y_LAST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      k_r     <= k_nxt;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> state_r == ST_IDLE) else $error("last pixel did not end glyph");
  a_wait_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |=> state_r == ST_EMIT) else $error("wait not followed by emit");

endmodule

// ===== sv/gar_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: font store, config registers, row buffer and the pixel pipeline.
module gar_datapath import gar_pkg::*; #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gar_cmd_t              cmd,
  output gar_status_t           status,
  input  logic [10:0]           in_font_address,
  input  logic [7:0]            in_font_byte,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_second_byte,
  input  logic [5:0]            in_attr_flags,
  input  logic [23:0]           in_fg_color,
  input  logic [23:0]           in_bg_color,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last_pixel
);

  localparam int XW        = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int ROW_BYTES = 2 * GLYPH_WIDTH;
  localparam int TOP_ROWS  = GLYPH_HEIGHT / 3;
  localparam int BOT_START = 2 * (GLYPH_HEIGHT / 3) - 1;

  // Configuration registers.
  logic [7:0] invalid_glyph_r;
  logic [8:0] dim_scale_r;
  logic [3:0] ul_offset_r;
  logic [7:0] ul_level_r;
  logic       bg_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_glyph_r <= 8'd63;
      dim_scale_r     <= 9'd128;
      ul_offset_r     <= 4'd1;
      ul_level_r      <= 8'd255;
      bg_bit_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INVALID_GLYPH:    invalid_glyph_r <= cfg_data[7:0];
          CFG_DIM_SCALE:        dim_scale_r     <= cfg_data;
          CFG_UNDERLINE_OFFSET: ul_offset_r     <= cfg_data[3:0];
          CFG_UNDERLINE_LEVEL:  ul_level_r      <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.font_write && in_font_address == 11'd0) begin
        bg_bit_r <= in_font_byte[0];
      end
    end
  end

  // Glyph and attributes of the character being rendered.
  logic [7:0]  code;
  logic [7:0]  x0_r, rowbase_r;
  logic [5:0]  attr_r;
  logic [23:0] fg_r, bg_r;

  assign code = (in_second_byte >= 8'd1 && in_second_byte <= 8'd127) ?
                invalid_glyph_r : in_char_code;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x0_r      <= 8'(code[3:0] * GLYPH_WIDTH);
      rowbase_r <= 8'(code[7:4] * GLYPH_HEIGHT);
      attr_r    <= in_attr_flags;
      fg_r      <= in_fg_color;
      bg_r      <= in_bg_color;
    end
  end

  // Font store and row fetch.
  logic [12:0] row_full, rd_addr_full;
  logic [7:0]  rd_data;
  logic        cap_v_r;
  logic [FETCH_W-1:0] cap_k_r;
  logic [7:0]  row_bytes_r [ROW_FETCH_BYTES];

  assign row_full     = 13'(rowbase_r) + 13'(cmd.y);
  assign rd_addr_full = 13'(row_full * 13'(ROW_BYTES)) + 13'(x0_r[7:3]) + 13'(cmd.fetch_k);

  gar_ram #(.WIDTH(8), .DEPTH(2048)) u_font (
    .clk     (clk),
    .wr_en   (cmd.font_write),
    .wr_addr (in_font_address),
    .wr_data (in_font_byte),
    .rd_en   (cmd.fetch),
    .rd_addr (rd_addr_full[10:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_v_r <= 1'b0;
    end else begin
      cap_v_r <= cmd.fetch;
    end
    cap_k_r <= cmd.fetch_k;
    if (cap_v_r) begin
      row_bytes_r[cap_k_r] <= rd_data;
    end
  end

  // Row image: font bits, italic shift, bold smear.
  logic [23:0]            row_bits;
  logic [GLYPH_WIDTH-1:0] on_v, it_v, bd_v;
  logic                   it_top, it_bot, ul_hit;
  logic [4:0]             ul_row;
  logic [7:0]             pix0;

  assign row_bits = {row_bytes_r[2], row_bytes_r[1], row_bytes_r[0]} >> x0_r[2:0];
  assign it_top   = attr_r[0] && 32'(cmd.y) < TOP_ROWS;
  assign it_bot   = attr_r[0] && 32'(cmd.y) >= BOT_START;
  assign ul_row   = 5'(GLYPH_HEIGHT) - {1'b0, ul_offset_r};
  assign ul_hit   = attr_r[2] && ul_offset_r >= 4'd1 &&
                    32'(ul_offset_r) <= GLYPH_HEIGHT && ul_row == {1'b0, cmd.y};

  always_comb begin
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      on_v[c] = row_bits[c] ^ bg_bit_r;
    end
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      it_v[c] = on_v[c];
      if (it_top && c > 0) begin
        it_v[c] = on_v[(c > 0) ? c - 1 : 0];
      end
      if (it_bot && c < GLYPH_WIDTH - 1) begin
        it_v[c] = on_v[(c < GLYPH_WIDTH - 1) ? c + 1 : c];
      end
    end
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      bd_v[c] = it_v[c];
      // A set pixel (255) exceeds the bold threshold; a clear one does not.
      if (attr_r[1] && c > 0 && it_v[(c > 0) ? c - 1 : 0] &&
          PIX_FULL > BOLD_THRESHOLD) begin
        bd_v[c] = 1'b1;
      end
    end
  end

  assign pix0 = ul_hit ? ul_level_r : (bd_v[cmd.x[XW-1:0]] ? PIX_FULL : 8'd0);

  // Pixel pipeline; the whole pipe holds while the output is stalled.
  logic        adv;
  logic        v1_r, v2_r, v3_r;
  logic        last1_r, last2_r, last3_r;
  logic [7:0]  pix1_r, p2_r, p_nxt;
  logic [16:0] prod1_r;
  logic [15:0] sum3_r [3];
  logic [7:0]  fg_ch [3];
  logic [7:0]  bg_ch [3];
  logic [7:0]  q_nxt [3];

  assign adv            = !out_valid || out_ready;
  assign status.advance = adv;
  assign status.busy    = v1_r || v2_r || v3_r;

  always_comb begin
    p_nxt = pix1_r;
    if (attr_r[3]) begin
      p_nxt = (prod1_r[16:8] > 9'd255) ? PIX_FULL : prod1_r[15:8];
    end
    if (attr_r[4]) begin
      p_nxt = ~p_nxt;
    end
    if (attr_r[5]) begin
      p_nxt = 8'd0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      fg_ch[ch] = fg_r[16 - 8 * ch +: 8];
      bg_ch[ch] = bg_r[16 - 8 * ch +: 8];
    end
  end

  // floor(s / 255) for s up to 255 * 255.
  always_comb begin
    logic [16:0] t;
    logic [16:0] u;
    for (int ch = 0; ch < 3; ch++) begin
      t         = 17'(sum3_r[ch]) + 17'd1;
      u         = t + (t >> 8);
      q_nxt[ch] = u[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= cmd.emit;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
    if (adv) begin
      last1_r <= cmd.last;
      pix1_r  <= pix0;
      prod1_r <= 17'(pix0) * 17'(dim_scale_r);
      last2_r <= last1_r;
      p2_r    <= p_nxt;
      last3_r <= last2_r;
      for (int ch = 0; ch < 3; ch++) begin
        sum3_r[ch] <= 16'(bg_ch[ch]) * 16'(PIX_FULL - p2_r) + 16'(fg_ch[ch]) * 16'(p2_r);
      end
      out_last_pixel <= last3_r;
      out_red        <= q_nxt[0];
      out_green      <= q_nxt[1];
      out_blue       <= q_nxt[2];
    end
  end

endmodule

// ===== sv/glyph_attribute_renderer_top.sv =====
`timescale 1ns / 1ps
// Top level of the glyph attribute renderer: controller plus datapath.
//
// Input channel (in_*): one transaction is either a font write (in_kind 0),
// which stores in_font_byte at in_font_address and produces nothing, or a
// render request (in_kind 1), which produces GLYPH_WIDTH*GLYPH_HEIGHT pixel
// transactions on the output channel in row-major order, the final one with
// out_last_pixel set. A font write to address 0 also sets the background
// polarity from bit 0 of its byte.
// Configuration (cfg_*): cfg_index selects invalid glyph, dim scale,
// underline offset or underline level; writes are taken in any cycle and
// must only be issued while the block is idle.
// Sequencing: each glyph row is three font-store reads through the single
// read port, a wait state while the read data is captured, then one pixel
// per cycle while the output is not stalled; pixels reach the output
// through the registered pixel pipeline. The next input transaction is
// taken once the last pixel has left the internal pipeline; a final pixel
// still waiting in the output register does not hold it off.
// Stalls: when out_ready is low with out_valid high, the whole pixel
// pipeline and the pixel sequencer's emit phase hold; font-store reads for
// a row still go ahead. Reset (synchronous, rst_n low) returns config
// registers to their defaults and empties the pipeline; the font store
// contents are undefined until written.
module glyph_attribute_renderer_top import gar_pkg::*; #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [10:0]           in_font_address,
  input  logic [7:0]            in_font_byte,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_second_byte,
  input  logic [5:0]            in_attr_flags,
  input  logic [23:0]           in_fg_color,
  input  logic [23:0]           in_bg_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last_pixel
);

  gar_cmd_t    cmd;
  gar_status_t status;

  // Configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  gar_ctrl #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gar_datapath #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .in_char_code    (in_char_code),
    .in_second_byte  (in_second_byte),
    .in_attr_flags   (in_attr_flags),
    .in_fg_color     (in_fg_color),
    .in_bg_color     (in_bg_color),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
